### design/bovl_pkg.sv
`default_nettype none
package bovl_pkg;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_MODIFY = 2'd2;
	localparam logic [1:0] MODE_SEARCH = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	localparam logic [4:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic       load;
		logic       rd_front;
		logic       walk;
		logic       scan_next;
		logic       ins_wr;
		logic       mod_wr;
		logic       del_wr;
		logic       out_load;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic front_null;
		logic full;
		logic hit;
		logic walk_last;
		logic slot_free;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

### design/bovl_ram.sv
`default_nettype none
module bovl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic                                    rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### design/bovl_ctrl.sv
`default_nettype none
module bovl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      mode,
	input  wire bovl_pkg::stat_t stat,
	output bovl_pkg::cmd_t       cmd
);
	import bovl_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic [1:0] fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_INSERT;
			fin_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			fin_q   <= fin_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		mode_d  = mode_q;
		fin_d   = fin_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					mode_d   = mode;
					if (mode == MODE_INSERT) begin
						if (stat.full) begin
							fin_d   = ST_FULL;
							state_d = S_FIN;
						end else begin
							state_d = S_SCAN;
						end
					end else if (stat.front_null) begin
						fin_d   = ST_MISSING;
						state_d = S_FIN;
					end else begin
						cmd.rd_front = 1'b1;
						state_d      = S_WALK;
					end
				end
			end
			S_SCAN: begin
				if (stat.slot_free) begin
					cmd.ins_wr = 1'b1;
					fin_d      = ST_OK;
					state_d    = S_FIN;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_WALK: begin
				if (stat.hit) begin
					case (mode_q)
						MODE_MODIFY: cmd.mod_wr = 1'b1;
						MODE_DELETE: cmd.del_wr = 1'b1;
						default: ;
					endcase
					fin_d   = ST_OK;
					state_d = S_FIN;
				end else if (stat.walk_last) begin
					fin_d   = ST_MISSING;
					state_d = S_FIN;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = fin_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### design/bovl_dp.sv
`default_nettype none
module bovl_dp #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [4:0]         cfg_wr_data,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] new_value,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [1:0]              status,
	output logic [4:0]              entry_total,
	input  wire bovl_pkg::cmd_t     cmd,
	output bovl_pkg::stat_t         stat
);
	import bovl_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = LW;
	localparam int WW = 32 + LW;
	localparam logic [LW-1:0] LINK_NULL = LW'(MAX_ENTRIES);

	logic [4:0]             cap_q;
	logic [LW-1:0]          front_q;
	logic [MAX_ENTRIES-1:0] in_use_q;
	logic [CW-1:0]          count_q;
	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [4:0]             total_q;
	logic [31:0]            key_q;
	logic [31:0]            nval_q;
	logic [IW-1:0]          cur_q;
	logic [LW-1:0]          pred_q;
	logic [31:0]            pred_val_q;
	logic [CW-1:0]          steps_q;
	logic [IW-1:0]          scan_q;

	logic [CW-1:0] lim;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [WW-1:0] ram_rdata;
	logic [31:0]   rd_val;
	logic [LW-1:0] rd_nxt;

	assign rd_val = ram_rdata[WW-1:LW];
	assign rd_nxt = ram_rdata[LW-1:0];

	always_comb begin
		if ({27'd0, cap_q} >= 32'(MAX_ENTRIES)) begin
			lim = CW'(MAX_ENTRIES);
		end else begin
			lim = CW'(cap_q);
		end
	end

	assign stat.front_null = (front_q == LINK_NULL);
	assign stat.full       = (count_q >= lim);
	assign stat.hit        = (rd_val == key_q);
	assign stat.walk_last  = (rd_nxt == LINK_NULL) || (steps_q == CW'(MAX_ENTRIES - 1));
	assign stat.slot_free  = !in_use_q[scan_q];
	assign stat.out_free   = !out_valid_q || out_ready;

	// one word per entry: value and forward link; the walk tracks the predecessor
	assign ram_we = cmd.ins_wr || cmd.mod_wr || (cmd.del_wr && (pred_q != LINK_NULL));

	always_comb begin
		if (cmd.ins_wr) begin
			ram_waddr = scan_q;
			ram_wdata = {nval_q, front_q};
		end else if (cmd.mod_wr) begin
			ram_waddr = cur_q;
			ram_wdata = {nval_q, rd_nxt};
		end else begin
			ram_waddr = pred_q[IW-1:0];
			ram_wdata = {pred_val_q, rd_nxt};
		end
	end

	assign ram_re    = cmd.rd_front || cmd.walk;
	assign ram_raddr = cmd.rd_front ? front_q[IW-1:0] : rd_nxt[IW-1:0];

	bovl_ram #(
		.WIDTH(WW),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			front_q     <= LINK_NULL;
			in_use_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.ins_wr) begin
				front_q          <= LW'(scan_q);
				in_use_q[scan_q] <= 1'b1;
				count_q          <= count_q + CW'(1);
			end
			if (cmd.del_wr) begin
				if (pred_q == LINK_NULL) begin
					front_q <= rd_nxt;
				end
				in_use_q[cur_q] <= 1'b0;
				if (count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= key;
			nval_q  <= new_value;
			cur_q   <= front_q[IW-1:0];
			pred_q  <= LINK_NULL;
			steps_q <= '0;
			scan_q  <= '0;
		end
		if (cmd.walk) begin
			pred_q     <= LW'(cur_q);
			pred_val_q <= rd_val;
			cur_q      <= rd_nxt[IW-1:0];
			steps_q    <= steps_q + CW'(1);
		end
		if (cmd.scan_next) begin
			scan_q <= scan_q + IW'(1);
		end
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			total_q  <= 5'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_total = total_q;

endmodule
`default_nettype wire

### design/bounded_ordered_value_list_unit.sv
// Insert scans the slots upward from zero to the lowest free one; a full list is refused without a scan.
// Delete, modify and search walk the list from the front, one store read a cycle, to a hit or the list end.
// One request is in flight at a time.
// The result register lets the next request be taken while a result waits.
// Reset: list empty, count zero, capacity 16; store contents are left undefined.
`default_nettype none
module bounded_ordered_value_list_unit #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [4:0]         cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         mode,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] new_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [4:0]              entry_total
);
	import bovl_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bovl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode    (mode),
		.stat    (stat),
		.cmd     (cmd)
	);

	bovl_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.key        (key),
		.new_value  (new_value),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.entry_total(entry_total),
		.cmd        (cmd),
		.stat       (stat)
	);

	a_ins_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> stat.slot_free)
		else $error("insert into a slot in use");

	a_walk_no_stop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (!stat.hit && !stat.walk_last))
		else $error("walk advanced past a hit or list end");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ins_wr, cmd.mod_wr, cmd.del_wr, cmd.out_load}))
		else $error("overlapping list updates");

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result overwrote a pending result");

endmodule
`default_nettype wire

### sim/bounded_ordered_value_list_unit_tb.sv
`timescale 1ns / 100ps
module bounded_ordered_value_list_unit_tb;
	import bovl_pkg::*;

	localparam int NSLOTS = 16;
	localparam int NPHASES = 8;
	localparam int PHASE_ITEMS = 155;
	localparam int PHASE_CAP [NPHASES] = '{16, 31, 1, 0, 5, 16, 2, 12};

	typedef struct {
		logic [1:0] status;
		logic [4:0] entry_total;
	} answer_t;

	class list_tracker;
		logic [4:0]  capacity;
		logic [31:0] slot_value [NSLOTS];
		int          next_slot [NSLOTS];
		int          prev_slot [NSLOTS];
		bit          used [NSLOTS];
		int          front;
		int          count;
		int          fail_count;
		answer_t     answers [$];

		function new();
			capacity = CAP_RESET;
			front = NSLOTS;
			count = 0;
			fail_count = 0;
			foreach (used[i])
				used[i] = 1'b0;
		endfunction

		function int find_slot(logic [31:0] k);
			int cur;
			int steps;
			cur = front;
			steps = 0;
			while (cur < NSLOTS && steps < NSLOTS) begin
				if (slot_value[cur] == k)
					return cur;
				cur = next_slot[cur];
				steps++;
			end
			return NSLOTS;
		endfunction

		function logic [31:0] pick_present_key();
			logic [31:0] vals [$];
			int cur;
			cur = front;
			while (cur < NSLOTS && vals.size() < NSLOTS) begin
				vals.push_back(slot_value[cur]);
				cur = next_slot[cur];
			end
			if (vals.size() == 0)
				return $urandom;
			return vals[$urandom_range(vals.size() - 1)];
		endfunction

		// predict one accepted request and queue its answer
		function void take_request(logic [1:0] m, logic [31:0] k, logic [31:0] v);
			answer_t a;
			int limit;
			int slot;
			int hit;
			int up_slot;
			int down_slot;
			case (m)
				MODE_INSERT: begin
					limit = (capacity > NSLOTS) ? NSLOTS : int'(capacity);
					slot = NSLOTS;
					for (int i = NSLOTS - 1; i >= 0; i--)
						if (!used[i])
							slot = i;
					if (count >= limit || slot == NSLOTS) begin
						a.status = ST_FULL;
					end else begin
						slot_value[slot] = v;
						next_slot[slot] = front;
						prev_slot[slot] = NSLOTS;
						if (front < NSLOTS)
							prev_slot[front] = slot;
						front = slot;
						used[slot] = 1'b1;
						count++;
						a.status = ST_OK;
					end
				end
				MODE_DELETE: begin
					hit = find_slot(k);
					if (hit == NSLOTS) begin
						a.status = ST_MISSING;
					end else begin
						up_slot = prev_slot[hit];
						down_slot = next_slot[hit];
						if (up_slot < NSLOTS)
							next_slot[up_slot] = down_slot;
						else
							front = down_slot;
						if (down_slot < NSLOTS)
							prev_slot[down_slot] = up_slot;
						used[hit] = 1'b0;
						if (count > 0)
							count--;
						a.status = ST_OK;
					end
				end
				MODE_MODIFY: begin
					hit = find_slot(k);
					if (hit == NSLOTS) begin
						a.status = ST_MISSING;
					end else begin
						slot_value[hit] = v;
						a.status = ST_OK;
					end
				end
				default: begin
					hit = find_slot(k);
					a.status = (hit == NSLOTS) ? ST_MISSING : ST_OK;
				end
			endcase
			a.entry_total = count[4:0];
			answers.push_back(a);
		endfunction

		function void check_answer(logic [1:0] st, logic [4:0] tot);
			answer_t a;
			if (answers.size() == 0) begin
				$error("result with no request pending: status %0d entry_total %0d", st, tot);
				fail_count++;
				return;
			end
			a = answers.pop_front();
			if (st !== a.status) begin
				$error("status: expected %0d, actual %0d", a.status, st);
				fail_count++;
			end
			if (tot !== a.entry_total) begin
				$error("entry_total: expected %0d, actual %0d", a.entry_total, tot);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_INSERT;
	logic [31:0] key = '0;
	logic [31:0] new_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [4:0]  entry_total;
	bit          calm = 1'b0;

	list_tracker tracker;

	bounded_ordered_value_list_unit #(
		.MAX_ENTRIES(NSLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.key(key),
		.new_value(new_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_total(entry_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				tracker.check_answer(status, entry_total);
			out_ready <= calm || ($urandom_range(99) >= 30);
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return 32'($urandom_range(5)) - 32'd2;
			4, 5: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic [1:0] m, input logic [31:0] k,
			input logic [31:0] v);
		if (!calm) begin
			while ($urandom_range(99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		new_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_request(m, k, v);
	endtask

	// hold off until every answer is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.answers.size() != 0)
			@(posedge clk);
		repeat (2 * NSLOTS + 8) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.capacity = cap;
		@(posedge clk);
	endtask

	initial begin
		logic [1:0]  m;
		logic [31:0] k;
		logic [31:0] v;
		int          r;
		int          ins_pct;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, extremes, duplicates, front/middle/tail removal, slot reuse
		send_request(MODE_SEARCH, 32'h0000_0000, $urandom);
		send_request(MODE_DELETE, 32'h8000_0000, $urandom);
		send_request(MODE_MODIFY, 32'h7fff_ffff, $urandom);
		send_request(MODE_INSERT, $urandom, 32'h8000_0000);
		send_request(MODE_INSERT, $urandom, 32'h7fff_ffff);
		send_request(MODE_INSERT, $urandom, 32'h0000_0000);
		send_request(MODE_INSERT, $urandom, 32'hffff_ffff);
		send_request(MODE_INSERT, $urandom, 32'h0000_0000);
		send_request(MODE_SEARCH, 32'h0000_0000, $urandom);
		send_request(MODE_MODIFY, 32'h0000_0000, 32'h5555_5555);
		send_request(MODE_SEARCH, 32'h0000_0000, $urandom);
		send_request(MODE_DELETE, 32'h0000_0000, $urandom);
		send_request(MODE_DELETE, 32'h0000_0000, $urandom);
		send_request(MODE_DELETE, 32'h7fff_ffff, $urandom);
		send_request(MODE_DELETE, 32'h8000_0000, $urandom);
		send_request(MODE_DELETE, 32'h5555_5555, $urandom);
		send_request(MODE_INSERT, $urandom, 32'haaaa_aaaa);
		send_request(MODE_SEARCH, 32'hffff_ffff, $urandom);
		send_request(MODE_MODIFY, 32'hffff_ffff, 32'h0000_0001);
		send_request(MODE_SEARCH, 32'hffff_ffff, $urandom);
		send_request(MODE_DELETE, 32'h0000_0001, $urandom);
		send_request(MODE_DELETE, 32'haaaa_aaaa, $urandom);
		send_request(MODE_SEARCH, 32'haaaa_aaaa, $urandom);

		for (int p = 0; p < NPHASES; p++) begin
			drain();
			write_capacity(PHASE_CAP[p][4:0]);
			calm = (p == 5);
			ins_pct = (p % 2 == 0) ? 55 : 10;
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < ins_pct) begin
					m = MODE_INSERT;
				end else begin
					case (r % 3)
						0: m = MODE_DELETE;
						1: m = MODE_MODIFY;
						default: m = MODE_SEARCH;
					endcase
				end
				if ($urandom_range(1) == 1 && tracker.count > 0)
					k = tracker.pick_present_key();
				else
					k = pick_value();
				v = pick_value();
				send_request(m, k, v);
			end
		end
		calm = 1'b0;
		drain();

		if (tracker.fail_count == 0 && tracker.answers.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
